/* design/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/tcpts_pkg.sv */
// Package: shared word types and option constants for the TCP option parser.
`timescale 1ns / 1ps
package tcpts_pkg;

  localparam int unsigned DEFAULT_OPTION_LIMIT = 11;

  localparam logic [7:0] KIND_END = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_WS  = 8'd3;
  localparam logic [7:0] KIND_TS  = 8'd8;
  localparam logic [7:0] KIND_ANY = 8'd0;
  localparam logic [7:0] TS_LEN   = 8'd10;
  localparam logic [7:0] MIN_LEN  = 8'd2;

  typedef struct packed {
    logic [7:0] opt_byte;
    logic       last_byte;
    logic       area_empty;
  } in_word_t;

  typedef struct packed {
    logic        ts_found;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic        ws_found;
    logic        status;
  } out_word_t;

endpackage

/* design/tcpts_if.sv */
// Interfaces: valid/ready channels for option bytes and parse results.
`timescale 1ns / 1ps
interface tcpts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic       last_byte;
  logic       area_empty;

  modport source (output valid, output opt_byte, output last_byte, output area_empty,
                  input ready);
  modport sink (input valid, input opt_byte, input last_byte, input area_empty,
                output ready);
  modport mon (input valid, input ready, input opt_byte, input last_byte, input area_empty);
endinterface

interface tcpts_out_if;
  logic        valid;
  logic        ready;
  logic        ts_found;
  logic [31:0] ts_value;
  logic [31:0] ts_echo;
  logic        ws_found;
  logic        status;

  modport source (output valid, output ts_found, output ts_value, output ts_echo,
                  output ws_found, output status, input ready);
  modport sink (input valid, input ts_found, input ts_value, input ts_echo,
                input ws_found, input status, output ready);
  modport mon (input valid, input ready, input ts_found, input ts_value, input ts_echo,
               input ws_found, input status);
endinterface

/* design/tcp_option_timestamp_ws_parser_core.sv */
// Top level: TCP option parser with input word register and result register.
`timescale 1ns / 1ps
// Takes one option byte per cycle unless stalled and gives one result word per
// header, on the byte flagged last or on an empty-area word. Each accepted word
// lands in an input register; the walker updates the header state and forms the
// result combinationally from that register, and the result is loaded into the
// output register, from which it shows. Throughput is one word every cycle;
// input stalls only while a finished result waits in the output register and
// the word in the input register would produce another.
module tcp_option_timestamp_ws_parser_core #(
  parameter int unsigned OPTION_LIMIT = tcpts_pkg::DEFAULT_OPTION_LIMIT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcpts_in_if.sink    in_i,
  tcpts_out_if.source out_o
);
  import tcpts_pkg::*;

  logic      s1_v_q;
  in_word_t  s1_q;
  logic      s1_res;
  logic      s1_go;
  logic      out_v_q, out_v_d;
  out_word_t out_q;
  out_word_t res;

  assign s1_res     = s1_q.last_byte || s1_q.area_empty;
  assign s1_go      = s1_v_q && (!s1_res || !out_v_q || out_o.ready);
  assign in_i.ready = !s1_v_q || s1_go;

  tcpts_walker #(
    .OPTION_LIMIT(OPTION_LIMIT)
  ) u_walker (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(s1_go),
    .word_i(s1_q),
    .res_o (res)
  );

  always_comb begin
    out_v_d = out_v_q;
    if (out_o.ready) out_v_d = 1'b0;
    if (s1_go && s1_res) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_v_q <= in_i.valid;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_q.opt_byte   <= in_i.opt_byte;
      s1_q.last_byte  <= in_i.last_byte;
      s1_q.area_empty <= in_i.area_empty;
    end
    if (s1_go && s1_res) out_q <= res;
  end

  assign out_o.valid    = out_v_q;
  assign out_o.ts_found = out_q.ts_found;
  assign out_o.ts_value = out_q.ts_value;
  assign out_o.ts_echo  = out_q.ts_echo;
  assign out_o.ws_found = out_q.ws_found;
  assign out_o.status   = out_q.status;

endmodule

/* design/tcpts_walker.sv */
// Option walker: per-header parse state and result word for one byte.
`timescale 1ns / 1ps
module tcpts_walker #(
  parameter int unsigned OPTION_LIMIT = tcpts_pkg::DEFAULT_OPTION_LIMIT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  tcpts_pkg::in_word_t  word_i,
  output tcpts_pkg::out_word_t res_o
);
  import tcpts_pkg::*;

  localparam int unsigned CntW = $clog2(OPTION_LIMIT + 1);
  localparam logic [CntW-1:0] CntLimit = CntW'(OPTION_LIMIT);

  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  phase_e         ph_q, ph_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]     left_q, left_d;
  logic [7:0]     kind_q, kind_d;
  logic [63:0]    ts_q, ts_d;
  logic           fts_q, fts_d;
  logic           fws_q, fws_d;
  logic           stop_q, stop_d;
  logic           mal_q, mal_d;

  logic [7:0]     b;
  logic [7:0]     fin_kind;
  logic           fin;
  logic [CntW-1:0] cnt_inc;

  always_comb begin
    b        = word_i.opt_byte;
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    kind_d   = kind_q;
    ts_d     = ts_q;
    fts_d    = fts_q;
    fws_d    = fws_q;
    stop_d   = stop_q;
    mal_d    = mal_q;
    fin      = 1'b0;
    fin_kind = KIND_ANY;
    cnt_inc  = (cnt_q < CntLimit) ? cnt_q + 1'b1 : cnt_q;

    if (!stop_q && !mal_q) begin
      unique case (ph_q)
        PH_LEN: begin
          if (b < MIN_LEN) begin
            mal_d = 1'b1;
          end else begin
            left_d = b - MIN_LEN;
            if (kind_q == KIND_TS && b == TS_LEN && !fts_q) begin
              kind_d = KIND_TS;
              ts_d   = '0;
            end else if (kind_q == KIND_WS) begin
              kind_d = KIND_WS;
            end else begin
              kind_d = KIND_ANY;
            end
            if (left_d == '0) begin
              fin      = 1'b1;
              fin_kind = kind_d;
            end else begin
              ph_d = PH_BODY;
              if (word_i.last_byte) mal_d = 1'b1;
            end
          end
        end
        PH_BODY: begin
          if (kind_q == KIND_TS) ts_d = {ts_q[55:0], b};
          left_d = left_q - 8'd1;
          if (left_d == '0) begin
            fin      = 1'b1;
            fin_kind = kind_q;
          end else if (word_i.last_byte) begin
            mal_d = 1'b1;
          end
        end
        default: begin
          if (b == KIND_END) begin
            stop_d = 1'b1;
          end else begin
            cnt_d = cnt_inc;
            if (b == KIND_NOP) begin
              if (cnt_inc >= CntLimit) stop_d = 1'b1;
            end else begin
              kind_d = b;
              ph_d   = PH_LEN;
              if (word_i.last_byte) mal_d = 1'b1;
            end
          end
        end
      endcase
    end

    if (fin) begin
      if (fin_kind == KIND_TS) fts_d = 1'b1;
      else if (fin_kind == KIND_WS) fws_d = 1'b1;
      ph_d   = PH_KIND;
      kind_d = KIND_ANY;
      if (cnt_q >= CntLimit) stop_d = 1'b1;
    end

    res_o.ts_found = fts_d;
    res_o.ts_value = fts_d ? ts_d[63:32] : 32'd0;
    res_o.ts_echo  = fts_d ? ts_d[31:0] : 32'd0;
    res_o.ws_found = fws_d;
    res_o.status   = mal_d;
    if (word_i.area_empty) res_o = '0;

    if (word_i.last_byte || word_i.area_empty) begin
      ph_d   = PH_KIND;
      cnt_d  = '0;
      left_d = '0;
      kind_d = '0;
      ts_d   = '0;
      fts_d  = 1'b0;
      fws_d  = 1'b0;
      stop_d = 1'b0;
      mal_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_KIND;
      cnt_q  <= '0;
      left_q <= '0;
      kind_q <= '0;
      ts_q   <= '0;
      fts_q  <= 1'b0;
      fws_q  <= 1'b0;
      stop_q <= 1'b0;
      mal_q  <= 1'b0;
    end else if (step_i) begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      left_q <= left_d;
      kind_q <= kind_d;
      ts_q   <= ts_d;
      fts_q  <= fts_d;
      fws_q  <= fws_d;
      stop_q <= stop_d;
      mal_q  <= mal_d;
    end
  end

endmodule

/* design/tcpts_checker.sv */
// Checker: port-level properties of the option parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tcpts_checker (
  input logic         clk_i,
  input logic         rst_ni,
  tcpts_in_if.sink    in_m,
  tcpts_out_if.source out_m
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_m.valid && !out_m.ready, out_m.valid && $stable(out_m.ts_value) && $stable(out_m.ts_echo) && $stable(out_m.status))
  `ASSERT_IMPLY(a_ts_zero, clk_i, rst_ni, out_m.valid && !out_m.ts_found, out_m.ts_value == 32'd0 && out_m.ts_echo == 32'd0)
  `ASSERT_IMPLY(a_reset_idle, clk_i, rst_ni, $past(!rst_ni), !out_m.valid)
  `ASSERT_IMPLY(a_ready_known, clk_i, rst_ni, 1'b1, !$isunknown(in_m.ready))

endmodule

bind tcp_option_timestamp_ws_parser_core tcpts_checker u_tcpts_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .in_m  (in_i),
  .out_m (out_o)
);
